@@ sv/gabs_pkg.sv @@
// Shared types and constants for the Goertzel AFSK bit slicer.
`timescale 1ns / 1ps
package gabs_pkg;

  // Width and fraction of the tone coefficients (Q2.14)
  localparam int COEF_WIDTH  = 16;
  localparam int COEF_FRAC   = 14;
  // Energy operands are cut to this many signed bits
  localparam int ENERGY_BITS = 30;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_COEF_MARK  = 2'd0;
  localparam logic [1:0] REG_COEF_SPACE = 2'd1;
  localparam logic [1:0] REG_SPB        = 2'd2;

  localparam logic signed [COEF_WIDTH-1:0] COEF_MARK_RST  = 16'sd31556;
  localparam logic signed [COEF_WIDTH-1:0] COEF_SPACE_RST = 16'sd32083;
  localparam logic [15:0]                  SPB_RST        = 16'd92;

  // "ZCZ" as the three older bytes, "C" as the newest one
  localparam logic [23:0] HDR_HEAD = 24'h5A435A;
  localparam logic [7:0]  HDR_TAIL = 8'h43;

  // Classification of one sample, made by the front part
  typedef struct packed {
    logic clr;   // capture start: clear all state first
    logic dec;   // this sample closes a bit period
  } item_flags_t;

  // Commands from the back sequencer to each tone lane
  typedef struct packed {
    logic clear;
    logic mul;
    logic upd;
    logic en0;
    logic en1;
    logic en2;
    logic en3;
  } tone_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_EN0,
    ST_EN1,
    ST_EN2,
    ST_EN3,
    ST_DEC
  } back_state_t;

endpackage

@@ sv/gabs_fifo.sv @@
// Two-entry command queue between the front and back parts.
`timescale 1ns / 1ps
module gabs_fifo #(
  parameter int W = 18
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ sv/gabs_front.sv @@
// Front part: accepts samples, counts the bit period and classifies each sample.
`timescale 1ns / 1ps
module gabs_front #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_clr,
  input  logic [15:0]                    spb,
  input  logic                           q_full,
  output logic                           push,
  output logic signed [SAMPLE_WIDTH-1:0] push_sample,
  output gabs_pkg::item_flags_t          push_flags
);

  logic [15:0] phase_r, phase_nxt;
  logic [15:0] phase_base;
  logic [16:0] phase_inc;
  logic [15:0] spb_eff;
  logic        closes;

  assign in_ready    = !q_full;
  assign push        = in_valid && !q_full;
  assign push_sample = in_sample;

  always_comb begin
    // a capture start restarts the count before this sample is counted
    phase_base = in_clr ? 16'd0 : phase_r;
    phase_inc  = {1'b0, phase_base} + 17'd1;
    spb_eff    = (spb == 16'd0) ? 16'd1 : spb;
    closes     = (phase_inc >= {1'b0, spb_eff});
    push_flags.clr = in_clr;
    push_flags.dec = closes;
    if (push) begin
      phase_nxt = closes ? 16'd0 : phase_inc[15:0];
    end else begin
      phase_nxt = phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 16'd0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

@@ sv/gabs_tone.sv @@
// One Goertzel tone lane: saturating recurrence and multi-step energy evaluation.
`timescale 1ns / 1ps
module gabs_tone #(
  parameter int ACC_WIDTH    = 40,
  parameter int SAMPLE_WIDTH = 16,
  localparam int EW   = (ACC_WIDTH > gabs_pkg::ENERGY_BITS) ? gabs_pkg::ENERGY_BITS : ACC_WIDTH,
  localparam int EN_W = 2 * EW + 3
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  gabs_pkg::tone_ctl_t                       ctl,
  input  logic signed [gabs_pkg::COEF_WIDTH-1:0]    coef,
  input  logic signed [SAMPLE_WIDTH-1:0]            sample,
  output logic signed [EN_W-1:0]                    energy
);

  localparam int PW  = ACC_WIDTH + gabs_pkg::COEF_WIDTH;
  localparam int QW  = ACC_WIDTH + 2;
  localparam int TW  = EW + 2;
  localparam int MW  = 2 * EW + 2;
  localparam int ESH = ACC_WIDTH - EW;
  localparam int ROUND_BIAS = (1 << gabs_pkg::COEF_FRAC) - 1;
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  function automatic logic signed [ACC_WIDTH-1:0] sat_acc(input logic signed [QW-1:0] v);
    logic signed [ACC_WIDTH-1:0] r;
    if (v > QW'(ACC_MAX)) begin
      r = ACC_MAX;
    end else if (v < QW'(ACC_MIN)) begin
      r = ACC_MIN;
    end else begin
      r = ACC_WIDTH'(v);
    end
    return r;
  endfunction

  logic signed [ACC_WIDTH-1:0] p1_r, p1_nxt;
  logic signed [ACC_WIDTH-1:0] p2_r, p2_nxt;
  logic signed [PW-1:0]        prod_r;
  logic signed [TW-1:0]        t_r;
  logic signed [MW-1:0]        sq_r;
  logic signed [EN_W-1:0]      acc_r;

  logic signed [EW-1:0]        e1, e2;
  logic signed [PW-1:0]        cmul_a, cmul_b, cmul_p;
  logic signed [PW-1:0]        bias, prod_b;
  logic signed [QW-1:0]        quot, diff, sum;
  logic signed [ACC_WIDTH-1:0] a_sat, b_sat, s_sat;
  logic signed [TW-1:0]        em_a_src;
  logic signed [EW-1:0]        em_b_src;
  logic signed [MW-1:0]        em_a, em_b, em_p;

  assign energy = acc_r;

  always_comb begin
    // floor shift down to the energy operand width
    e1 = EW'(p1_r >>> ESH);
    e2 = EW'(p2_r >>> ESH);

    // coefficient multiplier: coef * prev1 for the step, coef * e1 for the energy
    cmul_a = PW'(coef);
    cmul_b = ctl.en0 ? PW'(e1) : PW'(p1_r);
    cmul_p = cmul_a * cmul_b;

    // truncate toward zero: bias negative products before the shift
    bias   = prod_r[PW-1] ? PW'(ROUND_BIAS) : PW'(0);
    prod_b = prod_r + bias;
    quot   = QW'(prod_b >>> gabs_pkg::COEF_FRAC);
    b_sat  = sat_acc(quot);
    diff   = QW'(ACC_WIDTH'(sample)) - QW'(p2_r);
    a_sat  = sat_acc(diff);
    sum    = QW'(a_sat) + QW'(b_sat);
    s_sat  = sat_acc(sum);

    // energy multiplier: e1*e1, e2*e2, then t*e2
    em_a_src = ctl.en2 ? t_r : TW'(ctl.en0 ? e1 : e2);
    em_b_src = ctl.en0 ? e1 : e2;
    em_a     = MW'(em_a_src);
    em_b     = MW'(em_b_src);
    em_p     = em_a * em_b;

    p1_nxt = p1_r;
    p2_nxt = p2_r;
    if (ctl.clear) begin
      p1_nxt = '0;
      p2_nxt = '0;
    end else if (ctl.upd) begin
      p1_nxt = s_sat;
      p2_nxt = p1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= '0;
      p2_r <= '0;
    end else begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul || ctl.en0) begin
      prod_r <= cmul_p;
    end
    if (ctl.en0 || ctl.en1 || ctl.en2) begin
      sq_r <= em_p;
    end
    if (ctl.en1) begin
      t_r   <= TW'(prod_r >>> gabs_pkg::COEF_FRAC);
      acc_r <= EN_W'(sq_r);
    end else if (ctl.en2) begin
      acc_r <= acc_r + EN_W'(sq_r);
    end else if (ctl.en3) begin
      acc_r <= acc_r - EN_W'(sq_r);
    end
  end

endmodule

@@ sv/gabs_back.sv @@
// Back part: sequences the tone lanes, decides bits, packs bytes and holds the result word.
`timescale 1ns / 1ps
module gabs_back #(
  parameter int ACC_WIDTH    = 40,
  parameter int SAMPLE_WIDTH = 16,
  localparam int EW   = (ACC_WIDTH > gabs_pkg::ENERGY_BITS) ? gabs_pkg::ENERGY_BITS : ACC_WIDTH,
  localparam int EN_W = 2 * EW + 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  logic signed [SAMPLE_WIDTH-1:0] q_sample,
  input  gabs_pkg::item_flags_t          q_flags,
  output logic                           q_pop,
  output gabs_pkg::tone_ctl_t            ctl,
  output logic signed [SAMPLE_WIDTH-1:0] x,
  input  logic signed [EN_W-1:0]         mark_energy,
  input  logic signed [EN_W-1:0]         space_energy,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_bit,
  output logic [7:0]                     out_byte,
  output logic                           out_done,
  output logic                           out_found
);

  gabs_pkg::back_state_t state_r, state_nxt;

  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic                           dec_r;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_bit_r, out_done_r, out_found_r;
  logic [7:0]                     out_byte_r;
  logic [2:0]                     bit_pos_r;
  logic [7:0]                     byte_shift_r;
  logic [23:0]                    recent_r;
  logic                           seen_r;

  logic       out_free, out_load, cap_clear;
  logic       bit_dec, done_dec, found_dec;
  logic [7:0] shifted;

  assign x         = x_r;
  assign out_valid = out_valid_r;
  assign out_bit   = out_bit_r;
  assign out_byte  = out_byte_r;
  assign out_done  = out_done_r;
  assign out_found = out_found_r;
  assign out_free  = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gabs_pkg::ST_IDLE: begin
        if (!q_empty) state_nxt = gabs_pkg::ST_MUL;
      end
      gabs_pkg::ST_MUL: state_nxt = gabs_pkg::ST_ADD;
      gabs_pkg::ST_ADD: begin
        if (dec_r) begin
          state_nxt = gabs_pkg::ST_EN0;
        end else if (!q_empty) begin
          state_nxt = gabs_pkg::ST_MUL;
        end else begin
          state_nxt = gabs_pkg::ST_IDLE;
        end
      end
      gabs_pkg::ST_EN0: state_nxt = gabs_pkg::ST_EN1;
      gabs_pkg::ST_EN1: state_nxt = gabs_pkg::ST_EN2;
      gabs_pkg::ST_EN2: state_nxt = gabs_pkg::ST_EN3;
      gabs_pkg::ST_EN3: state_nxt = gabs_pkg::ST_DEC;
      gabs_pkg::ST_DEC: begin
        if (out_free) state_nxt = gabs_pkg::ST_IDLE;
      end
      default: state_nxt = gabs_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    ctl      = '0;
    case (state_r)
      gabs_pkg::ST_IDLE: q_pop = !q_empty;
      gabs_pkg::ST_MUL:  ctl.mul = 1'b1;
      gabs_pkg::ST_ADD: begin
        ctl.upd = 1'b1;
        q_pop   = !dec_r && !q_empty;
      end
      gabs_pkg::ST_EN0: ctl.en0 = 1'b1;
      gabs_pkg::ST_EN1: ctl.en1 = 1'b1;
      gabs_pkg::ST_EN2: ctl.en2 = 1'b1;
      gabs_pkg::ST_EN3: ctl.en3 = 1'b1;
      gabs_pkg::ST_DEC: out_load = out_free;
      default: begin
        q_pop    = 1'b0;
        out_load = 1'b0;
      end
    endcase
    cap_clear = q_pop && q_flags.clr;
    // a capture start overrides the update of the sample before it
    ctl.clear = cap_clear || out_load;
  end

  // bit decision and byte framing
  always_comb begin
    bit_dec   = (mark_energy > space_energy);
    shifted   = byte_shift_r | (8'(bit_dec) << bit_pos_r);
    done_dec  = (bit_pos_r == 3'd7);
    found_dec = done_dec && !seen_r && (recent_r == gabs_pkg::HDR_HEAD) &&
                (shifted == gabs_pkg::HDR_TAIL);
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gabs_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      bit_pos_r    <= 3'd0;
      byte_shift_r <= 8'd0;
      recent_r     <= 24'd0;
      seen_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cap_clear) begin
        bit_pos_r    <= 3'd0;
        byte_shift_r <= 8'd0;
        recent_r     <= 24'd0;
        seen_r       <= 1'b0;
      end else if (out_load) begin
        bit_pos_r <= bit_pos_r + 3'd1;
        if (done_dec) begin
          byte_shift_r <= 8'd0;
          recent_r     <= {recent_r[15:0], shifted};
          if (found_dec) seen_r <= 1'b1;
        end else begin
          byte_shift_r <= shifted;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_r   <= q_sample;
      dec_r <= q_flags.dec;
    end
    if (out_load) begin
      out_bit_r   <= bit_dec;
      out_byte_r  <= done_dec ? shifted : 8'd0;
      out_done_r  <= done_dec;
      out_found_r <= found_dec;
    end
  end

endmodule

@@ sv/goertzel_afsk_bit_slicer_core.sv @@
// Top level of the Goertzel AFSK bit slicer: stream ports, register port, front and back.
`timescale 1ns / 1ps
// Goertzel AFSK bit slicer. Each audio word drives two Goertzel recurrences,
// one tuned to the mark tone and one to the space tone. After samples_per_bit
// words (0 acts as 1) the two tone energies are compared and one result word
// comes out: bit 1 when the mark energy is strictly greater, else 0. Bits are
// packed LSB first into bytes framed from the capture start; byte_done marks
// the bit that completes a byte, and header_found rises once per capture on
// the first "ZCZC". A word with capture_start set clears all state before it
// is used. Recurrence values saturate at ACC_WIDTH bits.
// A word that does not close a bit period passes through the back part as a
// coefficient multiply, then a saturating add; a word that closes a period
// adds a four-step energy evaluation sharing one coefficient and one energy
// multiplier per tone, and then the decision. The back part sets the pace;
// a two-entry queue lets the input side keep accepting while it works, and a
// held result word stalls the back part at the decision until it is taken.
// Registers (byte address): 0x0 coef_mark, 0x4 coef_space (both signed
// Q2.14 in bits 15:0), 0x8 samples_per_bit (bits 15:0).
module goertzel_afsk_bit_slicer_core #(
  parameter int ACC_WIDTH    = 40,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     in_tdata,   // audio_sample, zero pad
  input  logic [0:0]                            in_tuser,   // capture_start
  // result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [15:0]                           out_tdata,  // bit_value, byte_value, zero pad
  output logic [1:0]                            out_tuser,  // byte_done, header_found
  // register port
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [gabs_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int EW   = (ACC_WIDTH > gabs_pkg::ENERGY_BITS) ? gabs_pkg::ENERGY_BITS : ACC_WIDTH;
  localparam int EN_W = 2 * EW + 3;
  localparam int QW   = SAMPLE_WIDTH + $bits(gabs_pkg::item_flags_t);

  // configuration registers
  logic signed [gabs_pkg::COEF_WIDTH-1:0] coef_mark_r, coef_mark_nxt;
  logic signed [gabs_pkg::COEF_WIDTH-1:0] coef_space_r, coef_space_nxt;
  logic [15:0]                            spb_r, spb_nxt;
  logic                                   cfg_wr;
  logic [1:0]                             cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    coef_mark_nxt  = coef_mark_r;
    coef_space_nxt = coef_space_r;
    spb_nxt        = spb_r;
    if (cfg_wr) begin
      case (cfg_idx)
        gabs_pkg::REG_COEF_MARK:  coef_mark_nxt  = cfg_pwdata[15:0];
        gabs_pkg::REG_COEF_SPACE: coef_space_nxt = cfg_pwdata[15:0];
        gabs_pkg::REG_SPB:        spb_nxt        = cfg_pwdata[15:0];
        default: begin
          // drop writes to unmapped addresses
          spb_nxt = spb_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      gabs_pkg::REG_COEF_MARK:  cfg_prdata = {16'd0, coef_mark_r};
      gabs_pkg::REG_COEF_SPACE: cfg_prdata = {16'd0, coef_space_r};
      gabs_pkg::REG_SPB:        cfg_prdata = {16'd0, spb_r};
      default:                  cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_mark_r  <= gabs_pkg::COEF_MARK_RST;
      coef_space_r <= gabs_pkg::COEF_SPACE_RST;
      spb_r        <= gabs_pkg::SPB_RST;
    end else begin
      coef_mark_r  <= coef_mark_nxt;
      coef_space_r <= coef_space_nxt;
      spb_r        <= spb_nxt;
    end
  end

  // front: accept and classify
  logic                           q_full, q_empty, q_push, q_pop;
  logic signed [SAMPLE_WIDTH-1:0] push_sample;
  gabs_pkg::item_flags_t          push_flags;
  logic [QW-1:0]                  q_rdata;
  logic signed [SAMPLE_WIDTH-1:0] q_sample;
  gabs_pkg::item_flags_t          q_flags;

  gabs_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_sample  (in_tdata[SAMPLE_WIDTH-1:0]),
    .in_clr     (in_tuser[0]),
    .spb        (spb_r),
    .q_full     (q_full),
    .push       (q_push),
    .push_sample(push_sample),
    .push_flags (push_flags)
  );

  // queue: hold classified words until the back part takes them
  gabs_fifo #(
    .W(QW)
  ) u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata({push_sample, push_flags}),
    .pop  (q_pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  assign q_sample = q_rdata[QW-1:$bits(gabs_pkg::item_flags_t)];
  assign q_flags  = q_rdata[$bits(gabs_pkg::item_flags_t)-1:0];

  // back: sequencer plus two tone lanes
  gabs_pkg::tone_ctl_t            ctl;
  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [EN_W-1:0]         mark_energy, space_energy;
  logic                           out_bit, out_done, out_found;
  logic [7:0]                     out_byte;

  gabs_back #(
    .ACC_WIDTH   (ACC_WIDTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_sample    (q_sample),
    .q_flags     (q_flags),
    .q_pop       (q_pop),
    .ctl         (ctl),
    .x           (x),
    .mark_energy (mark_energy),
    .space_energy(space_energy),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_bit     (out_bit),
    .out_byte    (out_byte),
    .out_done    (out_done),
    .out_found   (out_found)
  );

  gabs_tone #(
    .ACC_WIDTH   (ACC_WIDTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_tone_mark (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .coef  (coef_mark_r),
    .sample(x),
    .energy(mark_energy)
  );

  gabs_tone #(
    .ACC_WIDTH   (ACC_WIDTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_tone_space (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .coef  (coef_space_r),
    .sample(x),
    .energy(space_energy)
  );

  assign out_tdata = {7'd0, out_byte, out_bit};
  assign out_tuser = {out_found, out_done};

endmodule
